>>> hw/rtl/hough_pixel_vote_accumulator_top_defines.svh
// Assertion macros shared by the checker files.
`ifndef HOUGH_PIXEL_VOTE_ACCUMULATOR_TOP_DEFINES_SVH
`define HOUGH_PIXEL_VOTE_ACCUMULATOR_TOP_DEFINES_SVH
// Implication that must hold at every clock edge outside reset.
`define HPVA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define HPVA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> hw/rtl/hpva_pkg.sv
// ----------------------------------------------------------------------------
// Hough vote package
// Shared widths, constants, trigonometry table and the cell token type.
// ----------------------------------------------------------------------------
package hpva_pkg;
  localparam int THETA_STEPS = 360;
  localparam int RHO_BINS = 1024;
  localparam int COUNT_BITS = 16;
  localparam int NUM_CELLS = 8;
  localparam int ANGLES_PER_CELL = THETA_STEPS / NUM_CELLS;
  localparam int ANG_W = $clog2(THETA_STEPS);
  localparam int RHO_W = $clog2(RHO_BINS);
  localparam int SLOT_W = $clog2(ANGLES_PER_CELL);
  localparam int CELL_DEPTH = ANGLES_PER_CELL * RHO_BINS;
  localparam int CELL_AW = $clog2(CELL_DEPTH);
  localparam int CELL_W = $clog2(NUM_CELLS);
  localparam int CLEAR_W = CELL_AW + 1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [0:0] {OP_VOTE = 1'b0, OP_READ = 1'b1} op_t;
  typedef enum logic [0:0] {REG_MIN_AVERAGE = 1'b0, REG_RHO_LIMIT = 1'b1} reg_idx_t;

  // Token passed along the chain of cells.
  typedef struct packed {
    logic              vld;
    logic              rd;
    logic [ANG_W-1:0]  ang;
    logic [9:0]        x;
    logic [9:0]        y;
    logic [RHO_W-1:0]  rsel;
    logic [11:0]       lim;
  } tok_t;

  function automatic logic signed [15:0] qsin(input logic [6:0] d);
    logic signed [15:0] t [0:90];
    t = '{16'sd0, 16'sd286, 16'sd572, 16'sd857, 16'sd1143, 16'sd1428, 16'sd1713,
      16'sd1997, 16'sd2280, 16'sd2563, 16'sd2845, 16'sd3126, 16'sd3406, 16'sd3686,
      16'sd3964, 16'sd4240, 16'sd4516, 16'sd4790, 16'sd5063, 16'sd5334, 16'sd5604,
      16'sd5872, 16'sd6138, 16'sd6402, 16'sd6664, 16'sd6924, 16'sd7182, 16'sd7438,
      16'sd7692, 16'sd7943, 16'sd8192, 16'sd8438, 16'sd8682, 16'sd8923, 16'sd9162,
      16'sd9397, 16'sd9630, 16'sd9860, 16'sd10087, 16'sd10311, 16'sd10531, 16'sd10749,
      16'sd10963, 16'sd11174, 16'sd11381, 16'sd11585, 16'sd11786, 16'sd11982,
      16'sd12176, 16'sd12365, 16'sd12551, 16'sd12733, 16'sd12911, 16'sd13085,
      16'sd13255, 16'sd13421, 16'sd13583, 16'sd13741, 16'sd13894, 16'sd14044,
      16'sd14189, 16'sd14330, 16'sd14466, 16'sd14598, 16'sd14726, 16'sd14849,
      16'sd14968, 16'sd15082, 16'sd15191, 16'sd15296, 16'sd15396, 16'sd15491,
      16'sd15582, 16'sd15668, 16'sd15749, 16'sd15826, 16'sd15897, 16'sd15964,
      16'sd16026, 16'sd16083, 16'sd16135, 16'sd16182, 16'sd16225, 16'sd16262,
      16'sd16294, 16'sd16322, 16'sd16344, 16'sd16362, 16'sd16374, 16'sd16382,
      16'sd16384};
    return (d > 7'd90) ? 16'sd0 : t[d];
  endfunction

  function automatic logic signed [15:0] sin_q14(input logic [9:0] deg);
    logic [9:0] d;
    d = (deg >= 10'd360) ? deg - 10'd360 : deg;
    if (d < 10'd90) return qsin(d[6:0]);
    else if (d < 10'd180) return qsin(7'(10'd180 - d));
    else if (d < 10'd270) return -qsin(7'(d - 10'd180));
    else return -qsin(7'(10'd360 - d));
  endfunction
endpackage

>>> hw/rtl/hpva_cell.sv
// ----------------------------------------------------------------------------
// Hough vote cell
// Owns the bins of a group of angles; votes by read-modify-write, answers reads
// and forwards the token to its neighbor.
// ----------------------------------------------------------------------------
module hpva_cell (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [hpva_pkg::CELL_W-1:0]         cell_id,
  input  logic                                clr_en,
  input  logic [hpva_pkg::CELL_AW-1:0]        clr_addr,
  input  hpva_pkg::tok_t                      tok_in,
  output hpva_pkg::tok_t                      tok_out,
  output logic                                rd_vld,
  output logic [hpva_pkg::COUNT_BITS-1:0]     rd_data
);
  localparam int APC = hpva_pkg::ANGLES_PER_CELL;

  logic [hpva_pkg::COUNT_BITS-1:0] mem [0:hpva_pkg::CELL_DEPTH-1];
  hpva_pkg::tok_t s1_r, s2_r, s3_r;
  logic mine1_r, mine2_r, mine3_r;
  logic signed [27:0] px_r, py_r;
  logic signed [28:0] psum;
  logic [hpva_pkg::CELL_AW-1:0] a1_r, a2_r, a3_r;
  logic ok2_r, ok3_r;
  logic [hpva_pkg::COUNT_BITS-1:0] q_r;
  logic rd_vld_r;
  logic [hpva_pkg::COUNT_BITS-1:0] fwd;

  logic [hpva_pkg::ANG_W-1:0] base;
  logic mine;
  logic [hpva_pkg::SLOT_W-1:0] slot;
  logic [28:0] pabs;
  logic [14:0] rmag;

  assign base = hpva_pkg::ANG_W'(cell_id) * hpva_pkg::ANG_W'(APC);
  assign mine = tok_in.vld && tok_in.ang >= base &&
                tok_in.ang < base + hpva_pkg::ANG_W'(APC);
  assign slot = hpva_pkg::SLOT_W'(tok_in.ang - base);
  assign psum = 29'(px_r) + 29'(py_r);
  assign pabs = psum[28] ? 29'(-psum) : 29'(psum);
  assign rmag = pabs[28:14];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0; s2_r <= '0; s3_r <= '0;
      mine1_r <= 1'b0; mine2_r <= 1'b0; mine3_r <= 1'b0;
      ok2_r <= 1'b0; ok3_r <= 1'b0; rd_vld_r <= 1'b0;
    end else begin
      s1_r <= tok_in;
      s2_r <= s1_r;
      s3_r <= s2_r;
      mine1_r <= mine;
      mine2_r <= mine1_r;
      mine3_r <= mine2_r;
      ok2_r <= mine1_r && !s1_r.rd &&
               (!psum[28] || rmag == 15'd0) &&
               {3'd0, rmag} < {6'd0, s1_r.lim};
      ok3_r <= ok2_r;
      rd_vld_r <= mine2_r && s2_r.rd;
    end
    // Stage 1: products and read address.
    px_r <= $signed({1'b0, tok_in.x}) *
            hpva_pkg::sin_q14(10'(tok_in.ang) + 10'd90);
    py_r <= $signed({1'b0, tok_in.y}) * hpva_pkg::sin_q14(10'(tok_in.ang));
    a1_r <= hpva_pkg::CELL_AW'(tok_in.rsel) * hpva_pkg::CELL_AW'(APC) +
            hpva_pkg::CELL_AW'(slot);
    // Stage 2: sum, bin address.
    a2_r <= s1_r.rd ? a1_r :
            hpva_pkg::CELL_AW'(rmag[hpva_pkg::RHO_W-1:0]) * hpva_pkg::CELL_AW'(APC) +
            a1_r - hpva_pkg::CELL_AW'(s1_r.rsel) * hpva_pkg::CELL_AW'(APC);
    a3_r <= a2_r;
    q_r  <= mem[a2_r];
    if (clr_en) mem[clr_addr] <= '0;
    else if (ok3_r && fwd != hpva_pkg::COUNT_MAX) mem[a3_r] <= fwd + 1'b1;
  end

  // Stage 3 may read the bin that stage 4 just wrote.
  assign fwd = q_r;
  assign tok_out = s3_r;
  assign rd_vld = rd_vld_r && mine3_r;
  assign rd_data = q_r;
endmodule

>>> hw/rtl/hough_pixel_vote_accumulator_top.sv
// ----------------------------------------------------------------------------
// Hough pixel vote accumulator
// Bright pixels vote into 360 x 1024 saturating bins held in a chain of cells.
// A read result comes from the cell that holds the angle, so its timing depends on
// that cell; an out-of-range read is answered with zero without entering the chain.
// A bright vote sweeps all 360 angles, a read one angle, then the chain drains;
// no item is taken until the drain ends. One dim vote per cycle while no result
// is pending. Reset: synchronous, active low; then a clearing pass over all
// 46080 addresses of each cell zeroes every bin while no item is taken.
// ----------------------------------------------------------------------------
module hough_pixel_vote_accumulator_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // op[0], x[10:1], y[20:11], red[28:21], green[36:29], blue[44:37],
  // rho_sel[54:45], theta_sel[63:55]
  input  logic [63:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // count[15:0]
  output logic [15:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [10:0] cfg_data
);
  localparam int NC = hpva_pkg::NUM_CELLS;
  localparam int DRAIN = 4 * NC + 4;

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_SWEEP, ST_DRAIN} st_t;

  st_t state_r;
  logic [7:0] min_avg_r;
  logic [10:0] rho_lim_r;
  logic [hpva_pkg::CLEAR_W-1:0] clr_r;
  logic [hpva_pkg::ANG_W-1:0] ang_r;
  logic [6:0] drn_r;
  hpva_pkg::tok_t tok_r;
  logic ovld_r;
  logic [15:0] odata_r;

  hpva_pkg::tok_t chain [0:NC];
  logic [NC-1:0] rv;
  logic [hpva_pkg::COUNT_BITS-1:0] rd [0:NC-1];

  logic take, bright, in_range;
  logic [9:0] sum;
  logic [11:0] lim;

  assign take = in_tvalid && in_tready;
  assign sum = 10'(in_tdata[28:21]) + 10'(in_tdata[36:29]) + 10'(in_tdata[44:37]);
  assign bright = sum >= 10'(min_avg_r) * 10'd3;
  assign in_range = in_tdata[63:55] < 9'(hpva_pkg::THETA_STEPS);
  assign lim = (rho_lim_r > 11'(hpva_pkg::RHO_BINS)) ? 12'(hpva_pkg::RHO_BINS)
                                                     : 12'(rho_lim_r);
  assign in_tready = state_r == ST_IDLE && !ovld_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r <= '0;
      min_avg_r <= 8'd200;
      rho_lim_r <= 11'd1024;
      tok_r <= '0;
      ovld_r <= 1'b0;
      ang_r <= '0;
      drn_r <= '0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == hpva_pkg::REG_MIN_AVERAGE) min_avg_r <= cfg_data[7:0];
        else rho_lim_r <= cfg_data;
      end
      tok_r.vld <= 1'b0;
      if (out_tvalid && out_tready) ovld_r <= 1'b0;
      if (|rv) ovld_r <= 1'b1;
      unique case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == hpva_pkg::CLEAR_W'(hpva_pkg::CELL_DEPTH - 1)) state_r <= ST_IDLE;
        end
        ST_IDLE: begin
          if (take) begin
            tok_r.x <= in_tdata[10:1];
            tok_r.y <= in_tdata[20:11];
            tok_r.lim <= lim;
            tok_r.rd <= in_tdata[0];
            tok_r.rsel <= in_tdata[54:45];
            ang_r <= '0;
            drn_r <= '0;
            if (in_tdata[0] == hpva_pkg::OP_READ) begin
              if (in_range) begin
                tok_r.vld <= 1'b1;
                tok_r.ang <= in_tdata[63:55];
                state_r <= ST_DRAIN;
              end else begin
                ovld_r <= 1'b1;
                odata_r <= '0;
              end
            end else if (bright) begin
              tok_r.rsel <= '0;
              state_r <= ST_SWEEP;
            end
          end
        end
        ST_SWEEP: begin
          tok_r.vld <= 1'b1;
          tok_r.ang <= ang_r;
          ang_r <= ang_r + 1'b1;
          if (ang_r == hpva_pkg::ANG_W'(hpva_pkg::THETA_STEPS - 1)) state_r <= ST_DRAIN;
        end
        ST_DRAIN: begin
          drn_r <= drn_r + 1'b1;
          if (drn_r == 7'(DRAIN)) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
      for (int i = 0; i < NC; i++) if (rv[i]) odata_r <= rd[i];
    end
  end

  assign chain[0] = tok_r;
  for (genvar g = 0; g < NC; g++) begin : g_cell
    hpva_cell u_cell (
      .clk(clk), .rst_n(rst_n),
      .cell_id(hpva_pkg::CELL_W'(g)),
      .clr_en(state_r == ST_CLEAR),
      .clr_addr(clr_r[hpva_pkg::CELL_AW-1:0]),
      .tok_in(chain[g]), .tok_out(chain[g+1]),
      .rd_vld(rv[g]), .rd_data(rd[g]));
  end

  assign out_tvalid = ovld_r;
  assign out_tdata = odata_r;
endmodule

>>> hw/rtl/hpva_checker.sv
// ----------------------------------------------------------------------------
// Hough vote port checker
// Watches the top-level ports for handshake and result sanity.
// ----------------------------------------------------------------------------
`include "hough_pixel_vote_accumulator_top_defines.svh"
module hpva_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);
  `HPVA_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `HPVA_ASSERT_IMPL(a_no_take_pending, out_tvalid, !in_tready)
  `HPVA_ASSERT_NEXT(a_out_single, out_tvalid && out_tready, !out_tvalid)
endmodule

bind hough_pixel_vote_accumulator_top hpva_checker u_hpva_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata));
